[hdl/edd_pkg.sv]
// Shared types and constants for the encoder distance drive block.
// Used by edd_ctrl, edd_dp and encoder_distance_drive; no dependencies.
package edd_pkg;

  localparam int unsigned DIST_W   = 24;          // signed travel field
  localparam int unsigned REM_W    = 25;          // signed remaining distance
  localparam int unsigned DUTY_W   = 16;          // Q0.16 duty and speed
  localparam int unsigned STEP_W   = 12;
  localparam int unsigned ZONE_W   = 20;
  localparam int unsigned DECAY_W  = 16;
  localparam int unsigned CFG_W    = 20;          // widest register
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned QUO_W    = DUTY_W;      // divider quotient bits
  localparam int unsigned DIV_CNT_W = $clog2(QUO_W);

  localparam logic [STEP_W-1:0]  PULSE_STEP_RST   = 12'd147;
  localparam logic [ZONE_W-1:0]  SLOW_ZONE_RST    = 20'd2048;
  localparam logic [DECAY_W-1:0] DECAY_FACTOR_RST = 16'd58982;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_STEP   = 2'd0,
    CFG_SLOW_ZONE    = 2'd1,
    CFG_DECAY_FACTOR = 2'd2
  } edd_cfg_e;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_TICK  = 1'b1
  } edd_mode_e;

  typedef struct packed {
    logic                     mode;
    logic signed [DIST_W-1:0] left_distance;
    logic signed [DIST_W-1:0] right_distance;
    logic [DUTY_W-1:0]        start_speed;
    logic                     left_hall;
    logic                     right_hall;
  } edd_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic              left_reverse;
    logic              right_reverse;
    logic              moving;
  } edd_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the accepted transaction
    logic apply;     // start update or hall edge update
    logic decay;     // slow zone speed decay
    logic steer;     // pick duties, launch divider
    logic div_step;  // one restoring division step
    logic div_last;  // final step, write quotient to duty
    logic push;      // load output register
  } edd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tick_live; // captured item is a tick while a move runs
    logic need_div;  // steering needs a ratio
    logic out_free;  // output register can take a result
  } edd_sts_t;

endpackage

[hdl/encoder_distance_drive.sv]
// Top level of the encoder distance drive: controller plus datapath.
// Depends on edd_pkg, edd_ctrl and edd_dp.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------
//   in      | in_valid_i/in_ready_o  | in_data_i  (edd_in_t)
//   out     | out_valid_o/out_ready_i| out_data_o (edd_out_t)
//   cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A start transaction or an idle tick goes from the accepting edge through
// apply to push. A tick during a move goes through apply, decay and steer and,
// when steering needs a ratio, the 16-step restoring divider, one quotient bit
// a cycle, before push. A new transaction is taken only after push, so one item
// is in flight at a time. A full output register holds the sequencer in push
// until the waiting result is taken. Reset is asynchronous, active low, and
// leaves the block idle with register defaults loaded.
// Config is always ready.
module encoder_distance_drive (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  edd_pkg::edd_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output edd_pkg::edd_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [edd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [edd_pkg::CFG_W-1:0]     cfg_data_i
);
  import edd_pkg::*;

  edd_cmd_t cmd;
  edd_sts_t sts;

  assign cfg_ready_o = 1'b1;

  edd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  edd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/edd_ctrl.sv]
// Sequencer for the encoder distance drive: walks each transaction through
// apply, optional decay, steer and divide, and output. Depends on edd_pkg.
module edd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  edd_pkg::edd_sts_t sts_i,
  output edd_pkg::edd_cmd_t cmd_o
);
  import edd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_DECAY,
    ST_STEER,
    ST_DIV,
    ST_PUSH
  } state_e;

  state_e                state_q, state_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;

  localparam logic [DIV_CNT_W-1:0] CntLast = DIV_CNT_W'(QUO_W - 1);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = sts_i.tick_live ? ST_DECAY : ST_PUSH;
      end
      ST_DECAY: begin
        cmd_o.decay = 1'b1;
        state_d     = ST_STEER;
      end
      ST_STEER: begin
        cmd_o.steer = 1'b1;
        cnt_d       = '0;
        state_d     = sts_i.need_div ? ST_DIV : ST_PUSH;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          cmd_o.div_last = 1'b1;
          state_d        = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_accept_to_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_APPLY))
    else $error("accepted transaction did not enter apply");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == CntLast) |=> (state_q == ST_PUSH))
    else $error("divider did not finish after its last step");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> sts_i.out_free)
    else $error("result pushed into a full output register");

endmodule

[hdl/edd_dp.sv]
// Datapath of the encoder distance drive: config registers, move state,
// multipliers, restoring divider and output register. Depends on edd_pkg.
module edd_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  edd_pkg::edd_in_t                in_data_i,
  input  logic                            cfg_valid_i,
  input  logic [edd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [edd_pkg::CFG_W-1:0]       cfg_data_i,
  input  edd_pkg::edd_cmd_t               cmd_i,
  output edd_pkg::edd_sts_t               sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output edd_pkg::edd_out_t               out_data_o
);
  import edd_pkg::*;

  localparam logic signed [REM_W:0] RemMin = -(REM_W+1)'(2 ** (REM_W - 1));

  // configuration
  logic [STEP_W-1:0]  pulse_step_q;
  logic [ZONE_W-1:0]  slow_zone_q;
  logic [DECAY_W-1:0] decay_factor_q;

  // captured transaction and move state
  edd_in_t                 in_q;
  logic signed [REM_W-1:0] lrem_q, rrem_q;
  logic [DUTY_W-1:0]       speed_q;
  logic                    lhall_q, rhall_q;
  logic [DUTY_W-1:0]       lduty_q, rduty_q;
  logic                    lrev_q, rrev_q;
  logic                    active_q;

  // divider
  logic [DIST_W-1:0] rem_q, div_q;
  logic [QUO_W-1:0]  quo_q;
  logic              side_q;   // 0 writes left duty, 1 right

  // output register
  logic     out_valid_q;
  edd_out_t out_q;

  function automatic logic signed [REM_W-1:0] dec_sat(
    input logic signed [REM_W-1:0] r,
    input logic [STEP_W-1:0]       step
  );
    logic signed [REM_W:0] n;
    n = {r[REM_W-1], r} - $signed({{(REM_W+1-STEP_W){1'b0}}, step});
    if (n < RemMin) n = RemMin;
    return n[REM_W-1:0];
  endfunction

  // start: magnitudes and directions
  logic signed [REM_W-1:0] l_ext, r_ext, l_abs, r_abs;
  assign l_ext = REM_W'(in_q.left_distance);
  assign r_ext = REM_W'(in_q.right_distance);
  assign l_abs = l_ext[REM_W-1] ? -l_ext : l_ext;
  assign r_abs = r_ext[REM_W-1] ? -r_ext : r_ext;

  // decay
  logic signed [REM_W-1:0] zone_s;
  logic                    in_zone;
  logic [2*DUTY_W-1:0]     decay_prod;
  assign zone_s     = $signed({{(REM_W-ZONE_W){1'b0}}, slow_zone_q});
  assign in_zone    = (lrem_q < zone_s) || (rrem_q < zone_s);
  assign decay_prod = speed_q * decay_factor_q;

  // steering
  logic                      both_done, l_less, r_less;
  logic [DIST_W-1:0]         small_mag;
  logic [DUTY_W+DIST_W-1:0]  ratio_prod;
  assign both_done  = (lrem_q <= 0) && (rrem_q <= 0);
  assign l_less     = lrem_q < rrem_q;
  assign r_less     = rrem_q < lrem_q;
  assign small_mag  = l_less ? lrem_q[DIST_W-1:0] : rrem_q[DIST_W-1:0];
  assign ratio_prod = speed_q * small_mag;

  // restoring division step
  logic [DIST_W:0]   trial;
  logic              ge;
  logic [DIST_W:0]   diff;
  logic [QUO_W-1:0]  quo_next;
  assign trial    = {rem_q, quo_q[QUO_W-1]};
  assign ge       = trial >= {1'b0, div_q};
  assign diff     = trial - {1'b0, div_q};
  assign quo_next = {quo_q[QUO_W-2:0], ge};

  assign sts_o.tick_live = (in_q.mode == MODE_TICK) && active_q;
  assign sts_o.need_div  = !both_done &&
                           ((l_less && lrem_q > 0) || (r_less && rrem_q > 0));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_step_q   <= PULSE_STEP_RST;
      slow_zone_q    <= SLOW_ZONE_RST;
      decay_factor_q <= DECAY_FACTOR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PULSE_STEP:   pulse_step_q   <= cfg_data_i[STEP_W-1:0];
        CFG_SLOW_ZONE:    slow_zone_q    <= cfg_data_i[ZONE_W-1:0];
        CFG_DECAY_FACTOR: decay_factor_q <= cfg_data_i[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lrem_q   <= '0;
      rrem_q   <= '0;
      speed_q  <= '0;
      lhall_q  <= 1'b0;
      rhall_q  <= 1'b0;
      lduty_q  <= '0;
      rduty_q  <= '0;
      lrev_q   <= 1'b0;
      rrev_q   <= 1'b0;
      active_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        if (in_q.mode == MODE_START) begin
          lrev_q  <= in_q.left_distance < 0;
          rrev_q  <= in_q.right_distance < 0;
          lrem_q  <= l_abs;
          rrem_q  <= r_abs;
          speed_q <= in_q.start_speed;
          lhall_q <= 1'b0;
          rhall_q <= 1'b0;
          if (l_abs > 0 || r_abs > 0) begin
            lduty_q  <= in_q.start_speed;
            rduty_q  <= in_q.start_speed;
            active_q <= 1'b1;
          end else begin
            lduty_q  <= '0;
            rduty_q  <= '0;
            active_q <= 1'b0;
          end
        end else if (active_q) begin
          // left edge wins over right in the same sample
          if (in_q.left_hall != lhall_q) begin
            lrem_q  <= dec_sat(lrem_q, pulse_step_q);
            lhall_q <= in_q.left_hall;
          end else if (in_q.right_hall != rhall_q) begin
            rrem_q  <= dec_sat(rrem_q, pulse_step_q);
            rhall_q <= in_q.right_hall;
          end
        end
      end
      if (cmd_i.decay && in_zone) begin
        speed_q <= decay_prod[2*DUTY_W-1:DUTY_W];
      end
      if (cmd_i.steer) begin
        if (both_done) begin
          lduty_q  <= '0;
          rduty_q  <= '0;
          active_q <= 1'b0;
        end else if (l_less) begin
          rduty_q <= speed_q;
          if (!(lrem_q > 0)) lduty_q <= '0;
        end else if (r_less) begin
          lduty_q <= speed_q;
          if (!(rrem_q > 0)) rduty_q <= '0;
        end
      end
      if (cmd_i.div_last) begin
        if (side_q) rduty_q <= quo_next;
        else        lduty_q <= quo_next;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_data_i;
    if (cmd_i.steer) begin
      // product over 2^16 is below the divisor, so it seeds the remainder
      rem_q  <= ratio_prod[DUTY_W+DIST_W-1:QUO_W];
      quo_q  <= ratio_prod[QUO_W-1:0];
      div_q  <= l_less ? rrem_q[DIST_W-1:0] : lrem_q[DIST_W-1:0];
      side_q <= !l_less;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
      quo_q <= quo_next;
    end
    if (cmd_i.push) begin
      out_q.left_duty     <= lduty_q;
      out_q.right_duty    <= rduty_q;
      out_q.left_reverse  <= lrev_q;
      out_q.right_reverse <= rrev_q;
      out_q.moving        <= active_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_idle_duty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (lduty_q == '0 && rduty_q == '0))
    else $error("duty held while no move is running");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < div_q))
    else $error("divider remainder reached the divisor");

  a_rev_stable_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && in_q.mode == MODE_TICK) |=> ($stable(lrev_q) && $stable(rrev_q)))
    else $error("direction changed on a tick");

endmodule

[sim/edd_checker.sv]
// Checker for the encoder distance drive: mirrors the move state and compares every result.
// Watches the in, out and cfg channels of encoder_distance_drive; depends on edd_pkg.
module edd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  edd_pkg::edd_in_t              in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  edd_pkg::edd_out_t             out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [edd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [edd_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            outstanding_o,
  output int                            mismatches_o
);
  import edd_pkg::*;

  localparam int REM_FLOOR  = -(2 ** (REM_W - 1));
  localparam int REPORT_MAX = 10;

  logic [STEP_W-1:0]         step_q;
  logic [ZONE_W-1:0]         zone_q;
  logic [DECAY_W-1:0]        decay_q;

  logic signed [REM_W-1:0]   left_rem;
  logic signed [REM_W-1:0]   right_rem;
  logic [DUTY_W-1:0]         speed;
  logic [DUTY_W-1:0]         left_duty;
  logic [DUTY_W-1:0]         right_duty;
  logic                      left_hall_q;
  logic                      right_hall_q;
  logic                      left_rev;
  logic                      right_rev;
  logic                      moving;

  edd_out_t                  expected_drive_q[$];
  edd_out_t                  oldest;
  int                        fault_cnt = 0;

  assign mismatches_o = fault_cnt;

  // One hall edge worth of travel, held at the most negative remaining count.
  function automatic logic signed [REM_W-1:0] wear_down(input logic signed [REM_W-1:0] rem);
    int n;
    n = rem - int'(step_q);
    if (n < REM_FLOOR) n = REM_FLOOR;
    return REM_W'(n);
  endfunction

  function automatic logic [DUTY_W-1:0] ratio_duty(input int lesser, input int greater);
    longint unsigned q;
    if (lesser <= 0 || greater <= 0) return '0;
    q = (longint'(speed) * longint'(lesser)) / longint'(greater);
    return q[DUTY_W-1:0];
  endfunction

  function automatic edd_out_t next_drive_outputs(input edd_in_t item);
    int         l;
    int         r;
    int         zone;
    logic [31:0] prod;
    edd_out_t   res;
    if (item.mode == MODE_START) begin
      l = item.left_distance;
      r = item.right_distance;
      left_rev     = (l < 0);
      right_rev    = (r < 0);
      if (l < 0) l = -l;
      if (r < 0) r = -r;
      left_rem     = REM_W'(l);
      right_rem    = REM_W'(r);
      speed        = item.start_speed;
      left_hall_q  = 1'b0;
      right_hall_q = 1'b0;
      if (l > 0 || r > 0) begin
        left_duty  = speed;
        right_duty = speed;
        moving     = 1'b1;
      end else begin
        left_duty  = '0;
        right_duty = '0;
        moving     = 1'b0;
      end
    end else if (moving) begin
      // left edge wins when both levels moved
      if (item.left_hall != left_hall_q) begin
        left_rem    = wear_down(left_rem);
        left_hall_q = item.left_hall;
      end else if (item.right_hall != right_hall_q) begin
        right_rem    = wear_down(right_rem);
        right_hall_q = item.right_hall;
      end
      l    = left_rem;
      r    = right_rem;
      zone = zone_q;
      if (l < zone || r < zone) begin
        prod  = speed * decay_q;
        speed = prod[31:16];
      end
      if (l <= 0 && r <= 0) begin
        left_duty  = '0;
        right_duty = '0;
        moving     = 1'b0;
      end else if (l < r) begin
        right_duty = speed;
        left_duty  = ratio_duty(l, r);
      end else if (r < l) begin
        left_duty  = speed;
        right_duty = ratio_duty(r, l);
      end
    end
    res.left_duty     = left_duty;
    res.right_duty    = right_duty;
    res.left_reverse  = left_rev;
    res.right_reverse = right_rev;
    res.moving        = moving;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        = PULSE_STEP_RST;
      zone_q        = SLOW_ZONE_RST;
      decay_q       = DECAY_FACTOR_RST;
      left_rem      = '0;
      right_rem     = '0;
      speed         = '0;
      left_duty     = '0;
      right_duty    = '0;
      left_hall_q   = 1'b0;
      right_hall_q  = 1'b0;
      left_rev      = 1'b0;
      right_rev     = 1'b0;
      moving        = 1'b0;
      expected_drive_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (edd_cfg_e'(cfg_index_i))
          CFG_PULSE_STEP:   step_q  = cfg_data_i[STEP_W-1:0];
          CFG_SLOW_ZONE:    zone_q  = cfg_data_i[ZONE_W-1:0];
          CFG_DECAY_FACTOR: decay_q = cfg_data_i[DECAY_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_drive_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= REPORT_MAX)
            $display("[%0t] result with nothing expected: %p", $realtime, out_data_i);
        end else begin
          oldest = expected_drive_q.pop_front();
          if (out_data_i.left_duty !== oldest.left_duty ||
              out_data_i.right_duty !== oldest.right_duty ||
              out_data_i.left_reverse !== oldest.left_reverse ||
              out_data_i.right_reverse !== oldest.right_reverse ||
              out_data_i.moving !== oldest.moving) begin
            fault_cnt++;
            if (fault_cnt <= REPORT_MAX)
              $display("[%0t] mismatch: expected %0d/%0d %b/%b %b, got %0d/%0d %b/%b %b",
                       $realtime, oldest.left_duty, oldest.right_duty, oldest.left_reverse,
                       oldest.right_reverse, oldest.moving, out_data_i.left_duty,
                       out_data_i.right_duty, out_data_i.left_reverse,
                       out_data_i.right_reverse, out_data_i.moving);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_drive_q.push_back(next_drive_outputs(in_data_i));
      outstanding_o <= expected_drive_q.size();
    end
  end

endmodule

[sim/tb_top.sv]
// Testbench top for encoder_distance_drive: clock, reset, stimulus and the final verdict.
// Depends on edd_pkg, encoder_distance_drive and edd_checker.
module tb_top;
  import edd_pkg::*;

  localparam int          CLK_PERIOD     = 4;
  localparam int          RESET_CYCLES   = 4;
  localparam int unsigned CYCLE_LIMIT    = 800000;
  localparam int          TAIL_CYCLES    = 40;
  localparam int          DIST_MAX       = 8388607;
  localparam int          DIST_MIN       = -8388608;
  localparam int          OVERRUN_TICKS  = 40;

  localparam int FLIP_LEFT  = 0;
  localparam int FLIP_RIGHT = 1;
  localparam int FLIP_BOTH  = 2;
  localparam int FLIP_NONE  = 3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  edd_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  edd_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int          outstanding;
  int          mismatches;
  int          sent_cnt    = 0;
  int          burst_left  = 0;
  logic        left_lvl    = 1'b0;
  logic        right_lvl   = 1'b0;
  int unsigned cycle_cnt   = 0;
  int          stall_style = 0;
  int          style_left  = 0;
  int          stall_phase = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  encoder_distance_drive uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  edd_checker drive_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("encoder_distance_drive regression: fail");
      $finish;
    end
  end

  // Receiver: switch between free flow, light and heavy random stalls and a fixed duty pattern.
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      style_left  <= $urandom_range(16, 160);
    end else begin
      style_left <= style_left - 1;
    end
    stall_phase <= (stall_phase + 1) % 9;
    case (stall_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 2) == 0);
      default: out_ready <= (stall_phase < 4);
    endcase
  end

  function automatic edd_in_t start_item(input int l, input int r, input int spd);
    edd_in_t it;
    it.mode           = MODE_START;
    it.left_distance  = DIST_W'(l);
    it.right_distance = DIST_W'(r);
    it.start_speed    = DUTY_W'(spd);
    it.left_hall      = 1'($urandom);
    it.right_hall     = 1'($urandom);
    return it;
  endfunction

  // Distance and speed fields are don't-care on a tick; fill them with noise.
  function automatic edd_in_t tick_item(input logic lh, input logic rh);
    edd_in_t it;
    it.mode           = MODE_TICK;
    it.left_distance  = DIST_W'($urandom);
    it.right_distance = DIST_W'($urandom);
    it.start_speed    = DUTY_W'($urandom);
    it.left_hall      = lh;
    it.right_hall     = rh;
    return it;
  endfunction

  function automatic int pick_speed();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Keep travel to a handful of edges so moves actually finish.
  function automatic int pick_magnitude(input int step);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(1, 3);
      default: begin
        if (step == 0) return $urandom_range(0, 5000);
        return step * $urandom_range(0, 12) + $urandom_range(0, step - 1);
      end
    endcase
  endfunction

  task automatic send(input edd_in_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
    end
  endtask

  task automatic hall_tick(input int flip);
    case (flip)
      FLIP_LEFT:  left_lvl = ~left_lvl;
      FLIP_RIGHT: right_lvl = ~right_lvl;
      FLIP_BOTH: begin
        left_lvl  = ~left_lvl;
        right_lvl = ~right_lvl;
      end
      default: ;
    endcase
    send(tick_item(left_lvl, right_lvl));
  endtask

  // Hold off the sender until every result has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input edd_cfg_e idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input int step, input int zone, input int decay);
    drain();
    write_reg(CFG_PULSE_STEP, CFG_W'(step));
    write_reg(CFG_SLOW_ZONE, CFG_W'(zone));
    write_reg(CFG_DECAY_FACTOR, CFG_W'(decay));
    cfg_valid <= 1'b0;
  endtask

  // Start a move, then feed hall edges steered toward the side that still has travel.
  task automatic run_move(input int step, input bit cut_short);
    int lmag;
    int rmag;
    int lneed;
    int rneed;
    int n;
    int choice;
    lmag = pick_magnitude(step);
    rmag = ($urandom_range(0, 6) == 0) ? lmag : pick_magnitude(step);
    send(start_item($urandom_range(0, 1) ? -lmag : lmag,
                    $urandom_range(0, 1) ? -rmag : rmag, pick_speed()));
    left_lvl  = 1'b0;
    right_lvl = 1'b0;
    if (step == 0) begin
      lneed = $urandom_range(2, 8);
      rneed = $urandom_range(2, 8);
    end else begin
      lneed = (lmag + step - 1) / step;
      rneed = (rmag + step - 1) / step;
    end
    n = cut_short ? $urandom_range(0, lneed + rneed) : lneed + rneed + $urandom_range(0, 3);
    repeat (n) begin
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
        hall_tick(FLIP_BOTH);
      end else if (choice == 1) begin
        hall_tick(FLIP_NONE);
      end else if (lneed > 0 && (rneed == 0 || choice < 6)) begin
        lneed--;
        hall_tick(FLIP_LEFT);
      end else if (rneed > 0) begin
        rneed--;
        hall_tick(FLIP_RIGHT);
      end else begin
        hall_tick(choice < 6 ? FLIP_LEFT : FLIP_RIGHT);
      end
    end
  endtask

  task automatic random_phase(input int count, input int step);
    int stop_at;
    int roll;
    stop_at = sent_cnt + count;
    while (sent_cnt < stop_at) begin
      roll = $urandom_range(0, 19);
      if (roll < 15) begin
        run_move(step, 1'b0);
      end else if (roll < 17) begin
        run_move(step, 1'b1);
      end else if (roll == 17) begin
        // full-range travel: a move that will not finish before the next start
        send(start_item($urandom_range(0, 16777215) + DIST_MIN,
                        $urandom_range(0, 16777215) + DIST_MIN, pick_speed()));
        left_lvl  = 1'b0;
        right_lvl = 1'b0;
        repeat ($urandom_range(1, 6)) hall_tick($urandom_range(FLIP_LEFT, FLIP_NONE));
      end else if (roll == 18) begin
        repeat ($urandom_range(1, 5)) send(tick_item(1'($urandom), 1'($urandom)));
      end else begin
        drain();
      end
    end
  endtask

  initial begin : stimulus
    int step;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle ticks, empty start, extreme travel and speed, equal sides, move ends
    send(tick_item(1'b1, 1'b1));
    send(start_item(0, 0, 65535));
    send(tick_item(1'b1, 1'b0));
    send(start_item(DIST_MIN, DIST_MAX, 65535));
    send(tick_item(1'b1, 1'b0));
    send(tick_item(1'b1, 1'b1));
    send(tick_item(1'b1, 1'b1));
    send(start_item(DIST_MAX, DIST_MIN, 0));
    send(tick_item(1'b1, 1'b1));
    send(start_item(300, -300, 40000));
    send(tick_item(1'b0, 1'b0));
    send(tick_item(1'b1, 1'b0));
    send(tick_item(1'b1, 1'b1));
    send(tick_item(1'b0, 1'b1));
    send(tick_item(1'b1, 1'b1));
    send(tick_item(1'b1, 1'b0));
    send(tick_item(1'b1, 1'b1));
    send(tick_item(1'b0, 1'b0));
    send(start_item(1, 0, 12345));
    send(tick_item(1'b1, 1'b0));
    send(start_item(0, 5, 54321));
    send(tick_item(1'b0, 1'b1));

    set_config(4095, 0, 0);
    random_phase(130, 4095);
    set_config(1, 1048575, 65535);
    random_phase(130, 1);
    step = $urandom_range(2, 900);
    set_config(step, $urandom_range(0, 20000), $urandom_range(0, 65535));
    random_phase(130, step);
    // zero step: edges subtract nothing, only a new start ends a move
    set_config(0, $urandom_range(0, 4000), $urandom_range(0, 65535));
    random_phase(40, 0);
    step = $urandom_range(100, 4095);
    set_config(step, $urandom_range(0, 1048575), $urandom_range(0, 65535));
    random_phase(90, step);

    // keep counting left edges well past zero while the right side still has travel
    set_config(4095, $urandom_range(0, 1048575), $urandom_range(0, 65535));
    send(start_item(1, DIST_MAX, pick_speed()));
    left_lvl  = 1'b0;
    right_lvl = 1'b0;
    repeat (OVERRUN_TICKS) hall_tick(FLIP_LEFT);
    send(start_item(0, 0, pick_speed()));

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("encoder_distance_drive regression: pass");
    end else begin
      $display("encoder_distance_drive regression: fail");
    end
    $finish;
  end

endmodule

[encoder_distance_drive.f]
hdl/edd_pkg.sv
hdl/edd_ctrl.sv
hdl/edd_dp.sv
hdl/encoder_distance_drive.sv
sim/edd_checker.sv
sim/tb_top.sv
